// ===== rtl/core/frp_pkg.sv =====
// Package for the frame receiver parameter decoder.
// Holds the parser phase type, event and register codes, and decode constants.
// No dependencies.
`default_nettype none

package frp_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_LENGTH   = 2'd1,
        PH_PAYLOAD  = 2'd2,
        PH_CHECKSUM = 2'd3
    } phase_t;

    // Frame event codes
    typedef enum logic [1:0] {
        EVT_CHK_ERR = 2'd0,
        EVT_ACK     = 2'd1,
        EVT_DATA    = 2'd2,
        EVT_OTHER   = 2'd3
    } event_t;

    // Configuration register indexes
    localparam logic [1:0] REG_HEADER_CODE = 2'd0;
    localparam logic [1:0] REG_ACK_LENGTH  = 2'd1;
    localparam logic [1:0] REG_ACK_CODE    = 2'd2;
    localparam logic [1:0] REG_DATA_LENGTH = 2'd3;

    // Configuration reset values
    localparam logic [7:0] HEADER_CODE_RST = 8'd170;
    localparam logic [4:0] ACK_LENGTH_RST  = 5'd1;
    localparam logic [7:0] ACK_CODE_RST    = 8'd1;
    localparam logic [4:0] DATA_LENGTH_RST = 5'd10;

    // Decode constants
    localparam int         STORE_DEPTH = 10;
    localparam logic [7:0] DIR_LIMIT   = 8'd100;
    localparam logic [8:0] TRIM_BIAS   = 9'd20;

endpackage

`default_nettype wire

// ===== rtl/core/frame_receiver_param_decoder.sv =====
// Frame receiver parameter decoder: top level.
// Deframes length-prefixed byte frames with an 8-bit sum check and decodes data frames.
// Depends on frp_pkg.
//
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  rx_byte
// out       source     out_valid/out_stall  frame_event .. airframe_bits
// cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle, save when a checksum byte stalls. The parser state and the
// sum load at the edge that takes a byte, the output register at the edge that takes a
// checksum byte, so a frame's result is valid in the cycle right after that edge.
// Reset returns the parser to idle, clears the payload store and loads the
// register defaults. Only a checksum byte waits on a blocked output register;
// all other bytes are taken while a result is held. cfg_ready is always high.
`default_nettype none

module frame_receiver_param_decoder
    import frp_pkg::*;
#(
    parameter int MAX_LEN = 19
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        rx_byte,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             frame_event,
    output logic [2:0]             direction_bits,
    output logic [7:0]             roll_angle,
    output logic [7:0]             pitch_angle,
    output logic [7:0]             yaw_angle,
    output logic signed [8:0]      roll_rate,
    output logic signed [8:0]      pitch_rate,
    output logic signed [8:0]      yaw_rate,
    output logic signed [8:0]      roll_trim,
    output logic signed [8:0]      pitch_trim,
    output logic [7:0]             switch_bits,
    output logic [5:0]             airframe_bits,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam logic [7:0] MAX_LEN_B = 8'(MAX_LEN);

    // Configuration registers
    logic [7:0] header_code_reg;
    logic [4:0] ack_length_reg;
    logic [7:0] ack_code_reg;
    logic [4:0] data_length_reg;

    // Parser state
    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]  payload_pos_reg, payload_pos_next;
    logic [LEN_W-1:0]  frame_len_reg, frame_len_next;
    logic [7:0]        running_sum_reg, running_sum_next;
    logic [7:0]        store_reg [STORE_DEPTH];

    // Output register
    logic              out_valid_reg;
    logic [1:0]        event_reg;
    logic [2:0]        dir_reg;
    logic [7:0]        angle_reg [3];
    logic [8:0]        rate_reg [3];
    logic [8:0]        roll_trim_reg, pitch_trim_reg;
    logic [7:0]        switch_reg;
    logic [5:0]        airframe_reg;

    logic              accept;
    logic              store_we;
    logic              result_fire;
    logic [1:0]        event_next;
    logic [2:0]        dir_next;
    logic [7:0]        angle_next [3];
    logic [8:0]        rate_next [3];
    logic [8:0]        roll_trim_next, pitch_trim_next;
    logic [7:0]        switch_next;
    logic [5:0]        airframe_next;

    // Hold a checksum byte only while a result is blocked
    assign in_stall  = out_valid_reg && out_stall && (phase_reg == PH_CHECKSUM);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_code_reg <= HEADER_CODE_RST;
            ack_length_reg  <= ACK_LENGTH_RST;
            ack_code_reg    <= ACK_CODE_RST;
            data_length_reg <= DATA_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HEADER_CODE: header_code_reg <= cfg_data;
                REG_ACK_LENGTH:  ack_length_reg  <= cfg_data[4:0];
                REG_ACK_CODE:    ack_code_reg    <= cfg_data;
                REG_DATA_LENGTH: data_length_reg <= cfg_data[4:0];
                default:         header_code_reg <= header_code_reg;
            endcase
        end
    end

    // Next parser phase and counters
    always_comb
    begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        payload_pos_next = payload_pos_reg;
        frame_len_next   = frame_len_reg;
        running_sum_next = running_sum_reg;
        store_we         = 1'b0;
        result_fire      = 1'b0;
        if (accept)
        begin
            priority if (phase_reg == PH_IDLE && rx_byte == header_code_reg)
            begin
                phase_next       = PH_LENGTH;
                running_sum_next = rx_byte;
            end
            else if (phase_reg == PH_LENGTH && rx_byte <= MAX_LEN_B)
            begin
                phase_next       = PH_PAYLOAD;
                frame_len_next   = LEN_W'(rx_byte);
                bytes_left_next  = LEN_W'(rx_byte);
                payload_pos_next = '0;
                running_sum_next = running_sum_reg + rx_byte;
            end
            else if (phase_reg == PH_PAYLOAD && bytes_left_reg != '0)
            begin
                bytes_left_next  = bytes_left_reg - LEN_W'(1);
                phase_next       = (bytes_left_reg == LEN_W'(1)) ? PH_CHECKSUM : PH_PAYLOAD;
                payload_pos_next = payload_pos_reg + LEN_W'(1);
                running_sum_next = running_sum_reg + rx_byte;
                store_we         = 1'b1;
            end
            else if (phase_reg == PH_CHECKSUM)
            begin
                phase_next  = PH_IDLE;
                result_fire = 1'b1;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    // Classify the frame and decode the stored payload
    always_comb
    begin
        event_next      = EVT_OTHER;
        dir_next        = '0;
        roll_trim_next  = '0;
        pitch_trim_next = '0;
        switch_next     = '0;
        airframe_next   = '0;
        for (int i = 0; i < 3; i++)
        begin
            angle_next[i] = '0;
            rate_next[i]  = '0;
        end
        priority if (rx_byte != running_sum_reg)
        begin
            event_next = EVT_CHK_ERR;
        end
        else if (8'(frame_len_reg) == 8'(ack_length_reg) && store_reg[0] == ack_code_reg)
        begin
            event_next = EVT_ACK;
        end
        else if (8'(frame_len_reg) == 8'(data_length_reg))
        begin
            event_next = EVT_DATA;
            for (int i = 0; i < 3; i++)
            begin
                dir_next[i]   = store_reg[i] > DIR_LIMIT;
                angle_next[i] = dir_next[i] ? (store_reg[i] - DIR_LIMIT) : store_reg[i];
                rate_next[i]  = {1'b0, store_reg[3 + i]}
                                - (dir_next[i] ? {1'b0, DIR_LIMIT} : 9'd0);
            end
            roll_trim_next  = {1'b0, store_reg[6]} - TRIM_BIAS;
            pitch_trim_next = {1'b0, store_reg[7]} - TRIM_BIAS;
            switch_next     = store_reg[8];
            airframe_next   = store_reg[9][5:0];
        end
        else
        begin
            event_next = EVT_OTHER;
        end
    end

    // Advance parser state and write the payload store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bytes_left_reg  <= '0;
            payload_pos_reg <= '0;
            frame_len_reg   <= '0;
            running_sum_reg <= '0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            payload_pos_reg <= payload_pos_next;
            frame_len_reg   <= frame_len_next;
            running_sum_reg <= running_sum_next;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                if (store_we && payload_pos_reg == LEN_W'(i))
                begin
                    store_reg[i] <= rx_byte;
                end
            end
        end
    end

    // Output valid: load on a result, drop once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (result_fire)
        begin
            event_reg      <= event_next;
            dir_reg        <= dir_next;
            angle_reg      <= angle_next;
            rate_reg       <= rate_next;
            roll_trim_reg  <= roll_trim_next;
            pitch_trim_reg <= pitch_trim_next;
            switch_reg     <= switch_next;
            airframe_reg   <= airframe_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_event    = event_reg;
    assign direction_bits = dir_reg;
    assign roll_angle     = angle_reg[0];
    assign pitch_angle    = angle_reg[1];
    assign yaw_angle      = angle_reg[2];
    assign roll_rate      = rate_reg[0];
    assign pitch_rate     = rate_reg[1];
    assign yaw_rate       = rate_reg[2];
    assign roll_trim      = roll_trim_reg;
    assign pitch_trim     = pitch_trim_reg;
    assign switch_bits    = switch_reg;
    assign airframe_bits  = airframe_reg;

endmodule

`default_nettype wire

// ===== bench/frame_checker.sv =====
`timescale 1ns / 1ps
// Checker for the frame receiver parameter decoder: watches the byte, result and
// register channels, predicts each frame result and compares it field by field.
// Depends on frp_pkg.

module frame_checker
    import frp_pkg::*;
#(
    parameter int MAX_LEN = 19
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic [7:0]        rx_byte,

    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [1:0]        frame_event,
    input  wire logic [2:0]        direction_bits,
    input  wire logic [7:0]        roll_angle,
    input  wire logic [7:0]        pitch_angle,
    input  wire logic [7:0]        yaw_angle,
    input  wire logic [8:0]        roll_rate,
    input  wire logic [8:0]        pitch_rate,
    input  wire logic [8:0]        yaw_rate,
    input  wire logic [8:0]        roll_trim,
    input  wire logic [8:0]        pitch_trim,
    input  wire logic [7:0]        switch_bits,
    input  wire logic [5:0]        airframe_bits,

    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,

    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        event_t       evt;
        logic [2:0]   dirs;
        logic [7:0]   roll_a;
        logic [7:0]   pitch_a;
        logic [7:0]   yaw_a;
        logic [8:0]   roll_r;
        logic [8:0]   pitch_r;
        logic [8:0]   yaw_r;
        logic [8:0]   roll_t;
        logic [8:0]   pitch_t;
        logic [7:0]   sw;
        logic [5:0]   af;
    } frame_result_t;

    // Register copies
    logic [7:0] hdr_code;
    logic [4:0] ack_len;
    logic [7:0] ack_val;
    logic [4:0] data_len;

    // Parser copy
    phase_t     cur_phase;
    int         bytes_left;
    int         payload_pos;
    int         frame_len;
    logic [7:0] run_sum;
    logic [7:0] payload [0:STORE_DEPTH-1];

    frame_result_t expected_results [$];
    int            errors = 0;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Decode the stored payload into parameter fields
    task automatic decode_params(ref frame_result_t r);
        logic [2:0] d;
        for (int i = 0; i < 3; i++)
            d[i] = payload[i] > DIR_LIMIT;
        r.dirs    = d;
        r.roll_a  = payload[0] - (d[0] ? DIR_LIMIT : 8'd0);
        r.pitch_a = payload[1] - (d[1] ? DIR_LIMIT : 8'd0);
        r.yaw_a   = payload[2] - (d[2] ? DIR_LIMIT : 8'd0);
        r.roll_r  = {1'b0, payload[3]} - (d[0] ? {1'b0, DIR_LIMIT} : 9'd0);
        r.pitch_r = {1'b0, payload[4]} - (d[1] ? {1'b0, DIR_LIMIT} : 9'd0);
        r.yaw_r   = {1'b0, payload[5]} - (d[2] ? {1'b0, DIR_LIMIT} : 9'd0);
        r.roll_t  = {1'b0, payload[6]} - TRIM_BIAS;
        r.pitch_t = {1'b0, payload[7]} - TRIM_BIAS;
        r.sw      = payload[8];
        r.af      = payload[9][5:0];
    endtask

    // Advance the parser by one accepted byte
    task automatic parse_byte(input logic [7:0] b);
        frame_result_t r;
        if (cur_phase == PH_IDLE && b == hdr_code)
        begin
            cur_phase = PH_LENGTH;
            run_sum   = b;
        end
        else if (cur_phase == PH_LENGTH && int'(b) <= MAX_LEN)
        begin
            cur_phase   = PH_PAYLOAD;
            frame_len   = b;
            bytes_left  = b;
            payload_pos = 0;
            run_sum     = run_sum + b;
        end
        else if (cur_phase == PH_PAYLOAD && bytes_left > 0)
        begin
            bytes_left--;
            if (bytes_left == 0)
                cur_phase = PH_CHECKSUM;
            if (payload_pos < STORE_DEPTH)
                payload[payload_pos] = b;
            payload_pos++;
            run_sum = run_sum + b;
        end
        else if (cur_phase == PH_CHECKSUM)
        begin
            cur_phase = PH_IDLE;
            r = '0;
            if (b != run_sum)
                r.evt = EVT_CHK_ERR;
            else if (frame_len == int'(ack_len) && payload[0] == ack_val)
                r.evt = EVT_ACK;
            else if (frame_len == int'(data_len))
            begin
                r.evt = EVT_DATA;
                decode_params(r);
            end
            else
                r.evt = EVT_OTHER;
            expected_results.push_back(r);
        end
        else
            cur_phase = PH_IDLE;
    endtask

    // Compare one result transfer with the oldest prediction
    task automatic check_result();
        frame_result_t w;
        if (expected_results.size() == 0)
        begin
            report($sformatf("result with no frame pending, event %0d", frame_event));
            return;
        end
        w = expected_results.pop_front();
        if (frame_event !== w.evt)
            report($sformatf("frame_event got %0d exp %0d", frame_event, w.evt));
        if (direction_bits !== w.dirs)
            report($sformatf("direction_bits got %0d exp %0d", direction_bits, w.dirs));
        if (roll_angle !== w.roll_a)
            report($sformatf("roll_angle got %0d exp %0d", roll_angle, w.roll_a));
        if (pitch_angle !== w.pitch_a)
            report($sformatf("pitch_angle got %0d exp %0d", pitch_angle, w.pitch_a));
        if (yaw_angle !== w.yaw_a)
            report($sformatf("yaw_angle got %0d exp %0d", yaw_angle, w.yaw_a));
        if (roll_rate !== w.roll_r)
            report($sformatf("roll_rate got %h exp %h", roll_rate, w.roll_r));
        if (pitch_rate !== w.pitch_r)
            report($sformatf("pitch_rate got %h exp %h", pitch_rate, w.pitch_r));
        if (yaw_rate !== w.yaw_r)
            report($sformatf("yaw_rate got %h exp %h", yaw_rate, w.yaw_r));
        if (roll_trim !== w.roll_t)
            report($sformatf("roll_trim got %h exp %h", roll_trim, w.roll_t));
        if (pitch_trim !== w.pitch_t)
            report($sformatf("pitch_trim got %h exp %h", pitch_trim, w.pitch_t));
        if (switch_bits !== w.sw)
            report($sformatf("switch_bits got %0d exp %0d", switch_bits, w.sw));
        if (airframe_bits !== w.af)
            report($sformatf("airframe_bits got %0d exp %0d", airframe_bits, w.af));
    endtask

    // Sample every channel at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_code    = HEADER_CODE_RST;
            ack_len     = ACK_LENGTH_RST;
            ack_val     = ACK_CODE_RST;
            data_len    = DATA_LENGTH_RST;
            cur_phase   = PH_IDLE;
            bytes_left  = 0;
            payload_pos = 0;
            frame_len   = 0;
            run_sum     = '0;
            for (int i = 0; i < STORE_DEPTH; i++)
                payload[i] = '0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HEADER_CODE: hdr_code = cfg_data;
                    REG_ACK_LENGTH:  ack_len  = cfg_data[4:0];
                    REG_ACK_CODE:    ack_val  = cfg_data;
                    REG_DATA_LENGTH: data_len = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                parse_byte(rx_byte);
        end
        pending    <= expected_results.size();
        fail_count <= errors;
    end

endmodule

// ===== bench/tb_frame_receiver_param_decoder.sv =====
`timescale 1ns / 1ps
// Testbench top for the frame receiver parameter decoder: drives byte frames and
// register writes, paces the result side and gives the verdict.
// Depends on frp_pkg, frame_checker and the decoder RTL.

module tb_frame_receiver_param_decoder;
    import frp_pkg::*;

    localparam int MAX_LEN     = 19;
    localparam int ITEMS       = 1800;
    localparam int PHASE_BYTES = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 600000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [7:0]        rx_byte   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        frame_event;
    logic [2:0]        direction_bits;
    logic [7:0]        roll_angle;
    logic [7:0]        pitch_angle;
    logic [7:0]        yaw_angle;
    logic signed [8:0] roll_rate;
    logic signed [8:0] pitch_rate;
    logic signed [8:0] yaw_rate;
    logic signed [8:0] roll_trim;
    logic signed [8:0] pitch_trim;
    logic [7:0]        switch_bits;
    logic [5:0]        airframe_bits;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [7:0]        cfg_data  = '0;

    int fail_count;
    int pending;

    // Sender view of the registers
    logic [7:0] hdr_code = HEADER_CODE_RST;
    logic [4:0] ack_len  = ACK_LENGTH_RST;
    logic [7:0] ack_val  = ACK_CODE_RST;
    logic [4:0] data_len = DATA_LENGTH_RST;

    logic [7:0] pay [0:31];
    int         burst_left = 0;
    int         frame_bytes = 0;
    bit         hold_req = 1'b0;
    bit         hold_done = 1'b0;
    int         cycles = 0;

    frame_receiver_param_decoder #(.MAX_LEN(MAX_LEN)) dut (.*);

    frame_checker #(.MAX_LEN(MAX_LEN)) u_checker (.*);

    always #2 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Present one byte, in bursts with random gaps, and hold it until the transfer
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid = 1'b1;
        rx_byte  = b;
        burst_left--;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Send header, length, npay payload bytes and, when complete, the checksum
    task automatic send_frame(input logic [7:0] len_byte, input int npay, input bit bad_sum);
        logic [7:0] sum;
        sum = hdr_code + len_byte;
        send_byte(hdr_code);
        send_byte(len_byte);
        for (int i = 0; i < npay; i++)
        begin
            send_byte(pay[i]);
            sum = sum + pay[i];
        end
        frame_bytes += npay + 2;
        if (npay == int'(len_byte))
        begin
            send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
            frame_bytes++;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_HEADER_CODE: hdr_code = data;
            REG_ACK_LENGTH:  ack_len  = data[4:0];
            REG_ACK_CODE:    ack_val  = data;
            REG_DATA_LENGTH: data_len = data[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic drain();
        @(negedge clk);
        in_valid   = 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Bias payload bytes toward the decode boundaries
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'd100;
            1: return 8'd101;
            2: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            3: return 8'($urandom_range(19, 21));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Result side: random stall patterns, plus one long hold-off on request
    initial
    begin : receiver
        int mode;
        int span;
        int tick;
        mode = 0;
        span = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 4);
                    span = $urandom_range(20, 120);
                end
                span--;
                tick++;
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 7) == 0);
                    2: out_stall = ($urandom_range(0, 1) == 0);
                    3: out_stall = ($urandom_range(0, 7) != 0);
                    default: out_stall = (tick % 3 == 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int pick;
        int len;
        int setting;
        int next_switch;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle noise, data extremes, ack, bad sum, other, drops
        send_byte(8'h00);
        pay[0] = 8'd255; pay[1] = 8'd101; pay[2] = 8'd100; pay[3] = 8'd0;
        pay[4] = 8'd255; pay[5] = 8'd0;   pay[6] = 8'd0;   pay[7] = 8'd255;
        pay[8] = 8'd255; pay[9] = 8'd255;
        send_frame(8'd10, 10, 1'b0);
        pay[0] = ACK_CODE_RST;
        send_frame(8'd1, 1, 1'b0);
        send_frame(8'd1, 1, 1'b1);
        pay[0] = 8'd7;
        send_frame(8'd2, 2, 1'b0);
        // zero length: the checksum equals the header code and is dropped
        send_frame(8'd0, 0, 1'b0);
        send_frame(8'(MAX_LEN + 1), 0, 1'b0);

        // Random frames, changing the register setting every few hundred bytes
        setting = 0;
        next_switch = frame_bytes + PHASE_BYTES;
        while (frame_bytes < ITEMS)
        begin
            if (frame_bytes >= next_switch)
            begin
                drain();
                setting++;
                next_switch += PHASE_BYTES;
                case (setting)
                    1:
                    begin
                        write_reg(REG_HEADER_CODE, 8'h00);
                        write_reg(REG_ACK_LENGTH, 8'd19);
                        write_reg(REG_ACK_CODE, 8'hFF);
                        write_reg(REG_DATA_LENGTH, 8'd1);
                    end
                    2:
                    begin
                        // ack and data share a length; upper data bits are masked off
                        write_reg(REG_HEADER_CODE, 8'h55);
                        write_reg(REG_ACK_LENGTH, 8'd10);
                        write_reg(REG_ACK_CODE, 8'h7E);
                        write_reg(REG_DATA_LENGTH, 8'hEA);
                    end
                    3:
                    begin
                        write_reg(REG_HEADER_CODE, 8'hFF);
                        write_reg(REG_ACK_LENGTH, 8'd1);
                        write_reg(REG_ACK_CODE, 8'h00);
                        write_reg(REG_DATA_LENGTH, 8'd19);
                    end
                    4:
                    begin
                        write_reg(REG_HEADER_CODE, 8'($urandom_range(0, 255)));
                        write_reg(REG_ACK_LENGTH, 8'($urandom_range(1, MAX_LEN)));
                        write_reg(REG_ACK_CODE, 8'($urandom_range(0, 255)));
                        write_reg(REG_DATA_LENGTH, 8'($urandom_range(1, MAX_LEN)));
                    end
                    default:
                    begin
                        write_reg(REG_HEADER_CODE, HEADER_CODE_RST);
                        write_reg(REG_ACK_LENGTH, 8'(ACK_LENGTH_RST));
                        write_reg(REG_ACK_CODE, ACK_CODE_RST);
                        write_reg(REG_DATA_LENGTH, 8'(DATA_LENGTH_RST));
                    end
                endcase
            end
            if (!hold_req && frame_bytes >= ITEMS / 2)
                hold_req = 1'b1;

            for (int i = 0; i < 32; i++)
                pay[i] = rand_byte();
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_frame(8'(data_len), data_len, 1'b0);
            else if (pick < 55)
            begin
                pay[0] = ack_val;
                send_frame(8'(ack_len), ack_len, 1'b0);
            end
            else if (pick < 67)
            begin
                len = $urandom_range(1, MAX_LEN);
                send_frame(8'(len), len, 1'b0);
            end
            else if (pick < 77)
            begin
                len = $urandom_range(1, MAX_LEN);
                send_frame(8'(len), len, 1'b1);
            end
            else if (pick < 85)
            begin
                // truncated frame: the next frame's bytes land in its payload
                len = $urandom_range(2, MAX_LEN);
                send_frame(8'(len), $urandom_range(0, len - 1), 1'b0);
            end
            else if (pick < 90)
                send_frame(8'($urandom_range(MAX_LEN + 1, 255)), 0, 1'b0);
            else if (pick < 95)
                send_frame(8'd0, 0, 1'b0);
            else
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/frp_pkg.sv
rtl/core/frame_receiver_param_decoder.sv
bench/frame_checker.sv
bench/tb_frame_receiver_param_decoder.sv
